[rtl/core/hdlc_dfr_pkg.sv]
// ----------------------------------------------------------------------------
// hdlc_dfr_pkg
// Shared types and constants of the length-checked HDLC deframer.
// ----------------------------------------------------------------------------
package hdlc_dfr_pkg;

   localparam int unsigned MAX_FRAME_BYTES_DEFAULT = 4096;

   localparam logic [7:0]  STUFF_XOR       = 8'h20;
   localparam logic [12:0] LENGTH_OVERHEAD = 13'd6;

   localparam logic [7:0]  FLAG_RESET   = 8'h7E;
   localparam logic [7:0]  ESCAPE_RESET = 8'h7D;

   // Configuration register indexes
   localparam logic CSR_FLAG   = 1'b0;
   localparam logic CSR_ESCAPE = 1'b1;

   typedef enum logic [1:0] {
      EV_DATA  = 2'd0,
      EV_DONE  = 2'd1,
      EV_ERROR = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic           valid;
      event_kind_type kind;
      logic [7:0]     data_byte;
      logic [11:0]    byte_index;
      logic [12:0]    frame_length;
   } result_type;

endpackage

[rtl/core/hdlc_dfr_parser.sv]
// ----------------------------------------------------------------------------
// hdlc_dfr_parser
// Frame parser state and the per-byte decision: unstuff, count, length check.
// ----------------------------------------------------------------------------
module hdlc_dfr_parser
   import hdlc_dfr_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_i,
   input  logic [7:0] byte_i,
   input  logic [7:0] flag_i,
   input  logic [7:0] escape_i,
   output result_type result_o
);

   localparam logic [16:0] MaxLen = 17'(MAX_FRAME_BYTES);

   logic        header_seen_ff, header_seen_in;
   logic        escape_pending_ff, escape_pending_in;
   logic [12:0] received_count_ff, received_count_in;
   logic [12:0] expected_length_ff, expected_length_in;
   logic [7:0]  length_high_ff, length_high_in;

   logic        stuffed_ok;
   logic        clear;
   logic [7:0]  unstuffed;
   logic [12:0] count_plus;
   logic [16:0] payload_len;
   result_type  res;

   assign stuffed_ok  = (byte_i == (flag_i ^ STUFF_XOR)) || (byte_i == (escape_i ^ STUFF_XOR));
   assign unstuffed   = byte_i ^ (escape_pending_ff ? STUFF_XOR : 8'h00);
   assign count_plus  = received_count_ff + 13'd1;
   assign payload_len = {1'b0, length_high_ff, unstuffed} + 17'(LENGTH_OVERHEAD);

   always_comb begin
      header_seen_in     = header_seen_ff;
      escape_pending_in  = escape_pending_ff;
      received_count_in  = received_count_ff;
      expected_length_in = expected_length_ff;
      length_high_in     = length_high_ff;
      clear              = 1'b0;
      res                = '0;
      res.kind           = EV_DATA;

      if (escape_pending_ff && !stuffed_ok) begin
         clear    = 1'b1;
         res.valid = 1'b1;
         res.kind  = EV_ERROR;
      end else if (byte_i == flag_i) begin
         if (!header_seen_ff) begin
            header_seen_in = 1'b1;
         end else if (received_count_ff == 13'd0) begin
            // skip repeated opening flags
         end else if (received_count_ff < expected_length_ff) begin
            clear     = 1'b1;
            res.valid = 1'b1;
            res.kind  = EV_ERROR;
         end else begin
            clear            = 1'b1;
            res.valid        = 1'b1;
            res.kind         = EV_DONE;
            res.frame_length = received_count_ff;
         end
      end else if (byte_i == escape_i) begin
         escape_pending_in = 1'b1;
      end else if (!header_seen_ff) begin
         // drop bytes outside a frame
      end else if ({received_count_ff[12:1], 1'b0} >= expected_length_ff) begin
         clear     = 1'b1;
         res.valid = 1'b1;
         res.kind  = EV_ERROR;
      end else begin
         received_count_in = count_plus;
         escape_pending_in = 1'b0;
         if (received_count_ff == 13'd2) begin
            length_high_in = unstuffed;
         end
         res.valid      = 1'b1;
         res.kind       = EV_DATA;
         res.data_byte  = unstuffed;
         res.byte_index = received_count_ff[11:0];
         if (count_plus == 13'd4) begin
            if (payload_len > MaxLen) begin
               clear          = 1'b1;
               res            = '0;
               res.valid      = 1'b1;
               res.kind       = EV_ERROR;
            end else begin
               expected_length_in = payload_len[12:0];
            end
         end
      end

      if (clear) begin
         header_seen_in     = 1'b0;
         escape_pending_in  = 1'b0;
         received_count_in  = '0;
         expected_length_in = LENGTH_OVERHEAD;
         length_high_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_seen_ff     <= 1'b0;
         escape_pending_ff  <= 1'b0;
         received_count_ff  <= '0;
         expected_length_ff <= LENGTH_OVERHEAD;
         length_high_ff     <= '0;
      end else if (step_i) begin
         header_seen_ff     <= header_seen_in;
         escape_pending_ff  <= escape_pending_in;
         received_count_ff  <= received_count_in;
         expected_length_ff <= expected_length_in;
         length_high_ff     <= length_high_in;
      end
   end

   assign result_o = res;

`ifndef SYNTHESIS
   a_clear_after_event: assert property (@(posedge clock) disable iff (reset)
      step_i && res.valid && res.kind != EV_DATA |=>
         received_count_ff == 13'd0 && !header_seen_ff && !escape_pending_ff)
      else $error("parser state not cleared after completion or error");

   a_expected_floor: assert property (@(posedge clock) disable iff (reset)
      expected_length_ff >= LENGTH_OVERHEAD &&
      {4'd0, expected_length_ff} <= MaxLen + 17'(LENGTH_OVERHEAD))
      else $error("expected length out of range");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, received_count_ff} <= {1'b0, expected_length_ff} + 14'd1)
      else $error("received count ran past expected length");
`endif

endmodule

[rtl/core/hdlc_length_checked_deframer_core.sv]
// ----------------------------------------------------------------------------
// hdlc_length_checked_deframer_core
// HDLC byte-unstuffing deframer with a length check from the frame header.
// ----------------------------------------------------------------------------
// The block takes one raw link byte per word on req_ and returns at most one
// event word per byte on rsp_: an unstuffed data byte with its index in the
// frame, a frame-complete event carrying the byte count, or a frame error.
// A flag opens a frame; flags on an empty frame are skipped. An escape byte
// XORs the following byte with 0x20, and only the stuffed flag or stuffed
// escape may follow it. Data bytes 2 and 3 hold a big-endian length; plus six
// it sets the expected frame size, and a size above MAX_FRAME_BYTES is an
// error (the fourth data byte is then reported as the error). One odd pad byte
// past the expected size is accepted, a closing flag that arrives early is an
// error, and every completion or error resets the parser. Checksum
// verification is left to downstream logic. Throughput is one byte per clock
// while the output is not stalled: an input register feeds the parser's
// combinational decision, which writes the output register; a new byte is
// taken whenever the input register is empty or moving on. The flag and
// escape values are to be written through csr_ only while the block is idle;
// the block itself does not enforce this.
module hdlc_length_checked_deframer_core
   import hdlc_dfr_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // [7:0] data_byte, [19:8] byte_index,
                                     // [32:20] frame_length, [39:33] zero
   output logic [1:0]  rsp_tuser,    // [1:0] event_kind

   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   // configuration registers
   logic [7:0] flag_ff, flag_in;
   logic [7:0] escape_ff, escape_in;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // output register
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff, out_res_in;

   logic       req_fire;
   logic       advance;
   result_type parser_res;

   // Hand the held byte to the parser whenever the output slot is free or drains.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      flag_in   = flag_ff;
      escape_in = escape_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FLAG:   flag_in   = csr_wdata;
            CSR_ESCAPE: escape_in = csr_wdata;
            default:    ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata[7:0];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (advance) begin
         out_valid_in = parser_res.valid;
         if (parser_res.valid) begin
            out_res_in = parser_res;
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff      <= FLAG_RESET;
         escape_ff    <= ESCAPE_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         flag_ff      <= flag_in;
         escape_ff    <= escape_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_res_ff <= out_res_in;
   end

   hdlc_dfr_parser #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .step_i   (advance),
      .byte_i   (in_byte_ff),
      .flag_i   (flag_ff),
      .escape_i (escape_ff),
      .result_o (parser_res)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.kind;
   assign rsp_tdata  = {7'd0, out_res_ff.frame_length, out_res_ff.byte_index,
                        out_res_ff.data_byte};

`ifndef SYNTHESIS
   a_done_min_length: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.kind == EV_DONE |->
         out_res_ff.frame_length >= LENGTH_OVERHEAD)
      else $error("frame completed below minimum length");

   a_nondata_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.kind != EV_DATA |->
         out_res_ff.data_byte == 8'd0 && out_res_ff.byte_index == 12'd0)
      else $error("non-data event carries data fields");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input byte lost while output stalled");
`endif

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the length-checked HDLC deframer core. A frame
// tracker rebuilds the unstuffing and length-check state from every byte word
// the core accepts, queues the event it should emit, and checks each event
// word that leaves the core. The bench runs a short directed sequence first.
// It then runs random frames under several flag and escape settings, with
// bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb;
   import hdlc_dfr_pkg::*;

   localparam int unsigned MAX_BYTES    = MAX_FRAME_BYTES_DEFAULT;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned PHASE_ITEMS  = 200;
   localparam int unsigned NUM_PHASES   = 7;
   localparam int unsigned RANDOM_PHASE = 5;

   typedef enum int unsigned {
      END_CLEAN,
      END_EARLY,
      END_OVERRUN,
      END_BAD_ESCAPE
   } frame_end_type;

   typedef struct {
      event_kind_type kind;
      logic [7:0]     data_byte;
      logic [11:0]    byte_index;
      logic [12:0]    frame_length;
   } deframe_event_type;

   // Opening sequence at the reset flag and escape values.
   localparam logic [7:0] DIRECTED [28] = '{
      8'h41,                                  // data before any flag: skipped
      ESCAPE_RESET,                           // escape before any flag
      FLAG_RESET ^ STUFF_XOR,                 // stuffed byte, still no frame
      FLAG_RESET,                             // flag under pending escape: error
      FLAG_RESET,                             // open
      FLAG_RESET,                             // flag on empty frame: skipped
      8'h00, 8'hFF, 8'h00, 8'h01,             // header, length 1 -> 7 bytes
      ESCAPE_RESET, FLAG_RESET ^ STUFF_XOR,   // stuffed flag
      ESCAPE_RESET, ESCAPE_RESET ^ STUFF_XOR, // stuffed escape
      8'h80,                                  // last byte of the frame
      8'h01,                                  // odd pad byte
      FLAG_RESET,                             // complete, length 8
      FLAG_RESET, 8'h12, FLAG_RESET,          // early close: error
      FLAG_RESET, ESCAPE_RESET, 8'h41,        // bad stuffed byte: error
      FLAG_RESET, 8'h00, 8'h00, 8'h0F, 8'hFB  // length 4091 + 6: too large
   };

   localparam logic [7:0] PHASE_FLAG   [NUM_PHASES] =
      '{8'h7E, 8'h00, 8'hFF, 8'h55, 8'h7E, 8'h00, 8'h7E};
   localparam logic [7:0] PHASE_ESCAPE [NUM_PHASES] =
      '{8'h7D, 8'hFF, 8'h00, 8'h55, 8'h5E, 8'h00, 8'h7D};

   // -------------------------------------------------------------------------
   // Frame tracker: parser state, register copies and the pending events
   // -------------------------------------------------------------------------
   class frame_tracker;
      logic [7:0]  flag_byte;
      logic [7:0]  escape_byte;
      bit          in_frame;
      bit          esc_pending;
      logic [12:0] rx_count;
      logic [12:0] target_len;
      logic [7:0]  len_high;
      deframe_event_type queued[$];
      int unsigned errors;

      function new();
         flag_byte   = FLAG_RESET;
         escape_byte = ESCAPE_RESET;
         errors      = 0;
         clear_parser();
      endfunction

      function void clear_parser();
         in_frame    = 1'b0;
         esc_pending = 1'b0;
         rx_count    = '0;
         target_len  = LENGTH_OVERHEAD;
         len_high    = '0;
      endfunction

      function int unsigned outstanding();
         return queued.size();
      endfunction

      // Advance the parser by one raw byte and queue the event it causes.
      function void take_byte(logic [7:0] rx);
         deframe_event_type ev;
         bit             emit_ev;
         logic [7:0]     d;
         logic [12:0]    idx;
         int unsigned    plen;
         ev.kind         = EV_DATA;
         ev.data_byte    = '0;
         ev.byte_index   = '0;
         ev.frame_length = '0;
         emit_ev         = 1'b0;
         if (esc_pending && rx != (flag_byte ^ STUFF_XOR) &&
             rx != (escape_byte ^ STUFF_XOR)) begin
            ev.kind = EV_ERROR;
            emit_ev = 1'b1;
            clear_parser();
         end else if (rx == flag_byte) begin
            if (!in_frame) begin
               in_frame = 1'b1;
            end else if (rx_count != 0) begin
               emit_ev = 1'b1;
               if (rx_count < target_len) begin
                  ev.kind = EV_ERROR;
               end else begin
                  ev.kind         = EV_DONE;
                  ev.frame_length = rx_count;
               end
               clear_parser();
            end
         end else if (rx == escape_byte) begin
            esc_pending = 1'b1;
         end else if (in_frame) begin
            emit_ev = 1'b1;
            if ({rx_count[12:1], 1'b0} >= target_len) begin
               ev.kind = EV_ERROR;
               clear_parser();
            end else begin
               d           = esc_pending ? (rx ^ STUFF_XOR) : rx;
               idx         = rx_count;
               rx_count    = rx_count + 13'd1;
               esc_pending = 1'b0;
               if (idx == 13'd2) len_high = d;
               if (rx_count == 13'd4) begin
                  plen = {len_high, d} + LENGTH_OVERHEAD;
                  if (plen > MAX_BYTES) begin
                     ev.kind = EV_ERROR;
                     clear_parser();
                  end else begin
                     target_len = plen[12:0];
                  end
               end
               if (ev.kind == EV_DATA) begin
                  ev.data_byte  = d;
                  ev.byte_index = idx[11:0];
               end
            end
         end
         if (emit_ev) queued.push_back(ev);
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_event(event_kind_type kind, logic [7:0] data_byte,
                       logic [11:0] byte_index, logic [12:0] frame_length);
         deframe_event_type want;
         if (queued.size() == 0) begin
            report_mismatch($sformatf("event kind %0d with none pending", kind));
            return;
         end
         want = queued.pop_front();
         if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
         if (data_byte !== want.data_byte)
            report_mismatch($sformatf("data_byte %h, want %h", data_byte,
                                      want.data_byte));
         if (byte_index !== want.byte_index)
            report_mismatch($sformatf("byte_index %0d, want %0d", byte_index,
                                      want.byte_index));
         if (frame_length !== want.frame_length)
            report_mismatch($sformatf("frame_length %0d, want %0d", frame_length,
                                      want.frame_length));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and core signals; every input starts at a known value
   // -------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;     // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [7:0] data_byte, [19:8] byte_index,
                                     // [32:20] frame_length, [39:33] zero
   logic [1:0]  rsp_tuser;           // [1:0] event_kind
   logic        csr_we     = 1'b0;
   logic        csr_index  = CSR_FLAG;
   logic [7:0]  csr_wdata  = '0;

   frame_tracker tracker = new();
   logic [7:0]   tx_bytes[$];        // raw link bytes waiting to be sent
   int unsigned  cycle_count = 0;
   int unsigned  rx_mode     = 0;
   int unsigned  mode_left   = 0;

   always #1 clock = ~clock;

   hdlc_length_checked_deframer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Monitors: sample both handshakes at the rising edge. The core's outputs
   // only move after its own registers update, so these reads see the values
   // from before the edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) tracker.take_byte(req_tdata);
         if (rsp_tvalid && rsp_tready)
            tracker.check_event(event_kind_type'(rsp_tuser), rsp_tdata[7:0],
                                rsp_tdata[19:8], rsp_tdata[32:20]);
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Receiver back-pressure: switch among always-ready, coin-flip, mostly
   // stalled and a periodic pattern, holding each mode for a random span.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         rx_mode   = $urandom_range(0, 3);
         mode_left = $urandom_range(50, 400);
      end
      mode_left = mode_left - 1;
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ((mode_left % 16) < 5);
      endcase
   end

   // -------------------------------------------------------------------------
   // Stimulus tasks
   // -------------------------------------------------------------------------

   // Queue one data byte, stuffing it when it collides with flag or escape.
   task push_data(logic [7:0] d);
      if (d == tracker.flag_byte || d == tracker.escape_byte) begin
         tx_bytes.push_back(tracker.escape_byte);
         tx_bytes.push_back(d ^ STUFF_XOR);
      end else begin
         tx_bytes.push_back(d);
      end
   endtask

   // Queue one frame whose header carries body_len; the ending picks a clean
   // close, an early close, an overrun or a broken escape.
   task queue_frame(int unsigned body_len, frame_end_type ending);
      int unsigned total;
      int unsigned stop;
      int unsigned bad_at;
      logic [7:0]  d;
      total = body_len + LENGTH_OVERHEAD;
      stop  = total;
      if (body_len > MAX_BYTES - LENGTH_OVERHEAD) begin
         // the core drops the frame at the fourth byte; close right after it
         stop   = 4;
         ending = END_CLEAN;
      end else if (ending == END_EARLY) begin
         stop = $urandom_range(1, total - 1);
      end else if (ending == END_OVERRUN) begin
         stop = total + (total % 2) + 1;
      end else if ((total % 2) == 1 && $urandom_range(0, 1) == 1) begin
         stop = total + 1;      // odd pad byte
      end
      bad_at = $urandom_range(0, stop - 1);
      tx_bytes.push_back(tracker.flag_byte);
      if ($urandom_range(0, 7) == 0) tx_bytes.push_back(tracker.flag_byte);
      for (int unsigned i = 0; i < stop; i++) begin
         if (i == 2)
            d = body_len[15:8];
         else if (i == 3)
            d = body_len[7:0];
         else if ($urandom_range(0, 7) == 0)
            d = $urandom_range(0, 1) ? tracker.flag_byte : tracker.escape_byte;
         else
            d = 8'($urandom_range(0, 255));
         if (ending == END_BAD_ESCAPE && i == bad_at) begin
            tx_bytes.push_back(tracker.escape_byte);
            tx_bytes.push_back(8'($urandom_range(0, 255)));
         end
         push_data(d);
      end
      tx_bytes.push_back(tracker.flag_byte);
   endtask

   // Send every queued byte in bursts of random length with random gaps.
   task send_queued();
      int unsigned burst_left;
      int unsigned gap;
      logic [7:0]  b;
      burst_left = 0;
      while (tx_bytes.size() != 0) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               @(negedge clock);
               req_tvalid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         b = tx_bytes.pop_front();
         @(negedge clock);
         req_tvalid <= 1'b1;
         req_tdata  <= b;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         burst_left = burst_left - 1;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Wait for every pending event, then let the pipeline empty of bytes that
   // cause no event.
   task wait_idle();
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both registers while the core is idle.
   task write_registers(logic [7:0] flag_byte, logic [7:0] escape_byte);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_FLAG;
      csr_wdata <= flag_byte;
      @(negedge clock);
      csr_index <= CSR_ESCAPE;
      csr_wdata <= escape_byte;
      @(negedge clock);
      csr_we    <= 1'b0;
      tracker.flag_byte   = flag_byte;
      tracker.escape_byte = escape_byte;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int unsigned   pick;
      int unsigned   body_len;
      logic [7:0]    f;
      logic [7:0]    e;
      frame_end_type ending;

      // hold reset, then release it at a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening at the reset register values
      foreach (DIRECTED[i]) tx_bytes.push_back(DIRECTED[i]);
      send_queued();

      // random phases, one register setting each
      for (int unsigned p = 0; p < NUM_PHASES; p++) begin
         f = PHASE_FLAG[p];
         e = PHASE_ESCAPE[p];
         if (p == RANDOM_PHASE) begin
            f = 8'($urandom_range(0, 255));
            e = 8'($urandom_range(0, 255));
         end
         write_registers(f, e);
         while (tx_bytes.size() < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 90) begin
               pick = $urandom_range(0, 99);
               if (pick < 80)
                  body_len = $urandom_range(0, 20);
               else if (pick < 92)
                  body_len = $urandom_range(21, 200);
               else if (pick < 96)
                  body_len = $urandom_range(MAX_BYTES - LENGTH_OVERHEAD + 1, 65535);
               else
                  body_len = MAX_BYTES - LENGTH_OVERHEAD + 1;
               pick = $urandom_range(0, 99);
               if (pick < 75)
                  ending = END_CLEAN;
               else if (pick < 84)
                  ending = END_EARLY;
               else if (pick < 92)
                  ending = END_OVERRUN;
               else
                  ending = END_BAD_ESCAPE;
               queue_frame(body_len, ending);
            end else begin
               // raw line noise between frames
               repeat ($urandom_range(1, 5))
                  tx_bytes.push_back(8'($urandom_range(0, 255)));
            end
         end
         send_queued();
      end

      wait_idle();
      if (rsp_tvalid)
         tracker.report_mismatch("event word left over at the end");
      if (tracker.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
